// ===== src/engine_start_sequencer_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the engine start sequencer.
// Each macro expands to one labeled concurrent assertion on a given clock and
// active-low reset.
// ---------------------------------------------------------------------------
`ifndef ENGINE_START_SEQUENCER_CORE_ASSERT_SVH
`define ENGINE_START_SEQUENCER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ESS_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("engine start sequencer: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ESS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("engine start sequencer: next-cycle check failed");

`endif

// ===== src/ess_pkg.sv =====
// ---------------------------------------------------------------------------
// ess_pkg
// Types and constants shared by the engine start sequencer modules.
// ---------------------------------------------------------------------------
package ess_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MV_PER_COUNT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_DETECT_MV    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STARTER_STOP_MV  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IGNITION_DELAY   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRANK_LIMIT      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_RUN_MIN  = 3'd5;
    localparam int CFG_DATA_W = 16;

    // Configuration reset values.
    localparam logic [7:0]  RST_MV_PER_COUNT    = 8'd16;
    localparam logic [15:0] RST_RUN_DETECT_MV   = 16'd13300;
    localparam logic [15:0] RST_STARTER_STOP_MV = 16'd13000;
    localparam logic [15:0] RST_IGNITION_DELAY  = 16'd3000;
    localparam logic [15:0] RST_CRANK_LIMIT     = 16'd3000;
    localparam logic [7:0]  RST_DEFAULT_RUN_MIN = 8'd2;

    // Engine phase codes.
    localparam logic [1:0] PH_STOPPED  = 2'd0;
    localparam logic [1:0] PH_IGN_WAIT = 2'd1;
    localparam logic [1:0] PH_CRANKING = 2'd2;
    localparam logic [1:0] PH_RUNNING  = 2'd3;

    // Notification codes.
    localparam logic [2:0] NOTE_NONE        = 3'd0;
    localparam logic [2:0] NOTE_STARTED     = 3'd1;
    localparam logic [2:0] NOTE_START_FAIL  = 3'd2;
    localparam logic [2:0] NOTE_STOPPED     = 3'd3;
    localparam logic [2:0] NOTE_ALREADY_RUN = 3'd4;

    // Command kinds.
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    // Request codes.
    localparam logic [7:0] REQ_VOLTAGE  = 8'd4;
    localparam logic [7:0] REQ_STOP     = 8'd5;
    localparam logic [7:0] REQ_LED_A    = 8'd8;
    localparam logic [7:0] REQ_LED_B    = 8'd9;
    localparam logic [7:0] REQ_START_10 = 8'd10;
    localparam logic [7:0] REQ_START_15 = 8'd15;
    localparam logic [7:0] REQ_START_20 = 8'd20;
    localparam logic [7:0] REQ_START_25 = 8'd25;
    localparam logic [7:0] REQ_START_30 = 8'd30;

    // Response data codes.
    localparam logic [7:0] RSP_OK          = 8'd1;
    localparam logic [7:0] RSP_STARTING    = 8'd4;
    localparam logic [7:0] RSP_ALREADY_RUN = 8'd7;
    localparam logic [7:0] RSP_CODE_BASE   = 8'd128;

    // Argument value that selects the default (LED: no change).
    localparam logic [7:0] ARG_USE_DEFAULT = 8'd255;

    // Run timer rollover points: the counters roll once they pass these.
    localparam logic [9:0] MS_ROLL_LIMIT  = 10'd1000;
    localparam logic [5:0] SEC_ROLL_LIMIT = 6'd60;

    // Divide by 100 as multiply by ceil(2^23 / 100) and shift right by 23;
    // exact for every 16-bit dividend.
    localparam logic [16:0] DIV100_MULT  = 17'd83887;
    localparam int          DIV100_SHIFT = 23;

    typedef struct packed {
        logic [7:0]  mv_per_count;
        logic [15:0] run_detect_mv;
        logic [15:0] starter_stop_mv;
        logic [15:0] ignition_delay_ms;
        logic [15:0] crank_limit_ms;
        logic [7:0]  default_run_minutes;
    } t_cfg;

    typedef struct packed {
        logic        command;
        logic [7:0]  request_code;
        logic [7:0]  argument;
        logic [15:0] mv;
    } t_item;

    typedef struct packed {
        logic        has_response;
        logic [7:0]  response_code;
        logic [7:0]  response_data;
        logic        ignition_relay;
        logic        starter_relay;
        logic        led_drive;
        logic [2:0]  notify;
        logic [1:0]  engine_phase;
    } t_result;

endpackage

// ===== src/ess_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// ess_cfg_regs
// Configuration register file; takes one write per cycle.
// ---------------------------------------------------------------------------
module ess_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [ess_pkg::CFG_INDEX_W-1:0] i_index,
    input  logic [ess_pkg::CFG_DATA_W-1:0]  i_data,
    output logic                            o_ready,
    output ess_pkg::t_cfg                   o_cfg
);
    import ess_pkg::*;

    t_cfg r_cfg;

    // The register file never holds off a write.
    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mv_per_count        <= RST_MV_PER_COUNT;
            r_cfg.run_detect_mv       <= RST_RUN_DETECT_MV;
            r_cfg.starter_stop_mv     <= RST_STARTER_STOP_MV;
            r_cfg.ignition_delay_ms   <= RST_IGNITION_DELAY;
            r_cfg.crank_limit_ms      <= RST_CRANK_LIMIT;
            r_cfg.default_run_minutes <= RST_DEFAULT_RUN_MIN;
        end else if (i_valid) begin
            case (i_index)
                CFG_MV_PER_COUNT:    r_cfg.mv_per_count        <= i_data[7:0];
                CFG_RUN_DETECT_MV:   r_cfg.run_detect_mv       <= i_data;
                CFG_STARTER_STOP_MV: r_cfg.starter_stop_mv     <= i_data;
                CFG_IGNITION_DELAY:  r_cfg.ignition_delay_ms   <= i_data;
                CFG_CRANK_LIMIT:     r_cfg.crank_limit_ms      <= i_data;
                CFG_DEFAULT_RUN_MIN: r_cfg.default_run_minutes <= i_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== src/ess_input_stage.sv =====
// ---------------------------------------------------------------------------
// ess_input_stage
// Input register; scales the ADC sample to millivolts on the way in.
// ---------------------------------------------------------------------------
module ess_input_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_command,
    input  logic [7:0]          i_request_code,
    input  logic [7:0]          i_argument,
    input  logic [9:0]          i_adc_count,
    input  logic [7:0]          i_mv_per_count,
    input  logic                i_take,
    output logic                o_item_valid,
    output ess_pkg::t_item      o_item
);
    import ess_pkg::*;

    logic        r_valid;
    t_item       r_item;
    logic        accept;
    logic [17:0] mv_full;

    // The register frees up when the step stage takes its item.
    assign o_in_stall   = r_valid && !i_take;
    assign accept       = i_in_valid && !o_in_stall;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    // Battery voltage, truncated to 16 bits.
    assign mv_full = 18'(i_adc_count) * 18'(i_mv_per_count);

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.command      <= i_command;
            r_item.request_code <= i_request_code;
            r_item.argument     <= i_argument;
            r_item.mv           <= mv_full[15:0];
        end
    end

endmodule

// ===== src/ess_step.sv =====
// ---------------------------------------------------------------------------
// ess_step
// Start sequence state, per-item update and the result register.
// ---------------------------------------------------------------------------
module ess_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    input  ess_pkg::t_item      i_item,
    input  ess_pkg::t_cfg       i_cfg,
    output logic                o_take,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ess_pkg::t_result    o_result
);
    import ess_pkg::*;

    // Sequencer state.
    logic [1:0]  r_phase,   n_phase;
    logic        r_ign,     n_ign;
    logic        r_starter, n_starter;
    logic        r_led,     n_led;
    logic        r_timed,   n_timed;
    logic [7:0]  r_min,     n_min;
    logic [15:0] r_seq,     n_seq;
    logic [9:0]  r_ms,      n_ms;
    logic [5:0]  r_sec,     n_sec;

    // Result register.
    logic        r_out_valid;
    t_result     r_result;
    t_result     n_result;

    logic        out_free;
    logic [32:0] div_prod;

    // The result register can load when empty or being drained.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_take      = i_item_valid && out_free;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    // Voltage in units of 100 mV.
    assign div_prod = 33'(i_item.mv) * 33'(DIV100_MULT);

    // Next state and result for the item in the input register.
    always_comb begin
        n_phase   = r_phase;
        n_ign     = r_ign;
        n_starter = r_starter;
        n_led     = r_led;
        n_timed   = r_timed;
        n_min     = r_min;
        n_seq     = r_seq;
        n_ms      = r_ms;
        n_sec     = r_sec;
        n_result  = '0;

        if (i_item.command == CMD_TICK) begin
            case (r_phase)
                PH_IGN_WAIT: begin
                    if (r_seq >= i_cfg.ignition_delay_ms) begin
                        n_starter = 1'b1;
                        n_phase   = PH_CRANKING;
                        n_seq     = '0;
                    end else begin
                        n_seq = r_seq + 16'd1;
                    end
                end
                PH_CRANKING: begin
                    if (i_item.mv >= i_cfg.starter_stop_mv) begin
                        n_starter       = 1'b0;
                        n_phase         = PH_RUNNING;
                        n_result.notify = NOTE_STARTED;
                    end else if (r_seq >= i_cfg.crank_limit_ms) begin
                        n_starter       = 1'b0;
                        n_ign           = 1'b0;
                        n_phase         = PH_STOPPED;
                        n_result.notify = NOTE_START_FAIL;
                    end else begin
                        n_seq = r_seq + 16'd1;
                    end
                end
                PH_RUNNING: begin
                    if (r_timed) begin
                        if (r_min != 8'd0) begin
                            // Millisecond, second and minute counters.
                            n_ms = r_ms + 10'd1;
                            if (n_ms > MS_ROLL_LIMIT) begin
                                n_sec = r_sec + 6'd1;
                                n_ms  = '0;
                            end
                            if (n_sec > SEC_ROLL_LIMIT) begin
                                n_min = r_min - 8'd1;
                                n_sec = '0;
                            end
                        end else begin
                            n_ign           = 1'b0;
                            n_phase         = PH_STOPPED;
                            n_timed         = 1'b0;
                            n_result.notify = NOTE_STOPPED;
                        end
                    end
                end
                default: begin
                end
            endcase
        end else if (r_phase != PH_IGN_WAIT && r_phase != PH_CRANKING) begin
            // Requests are served only outside the start sequence.
            case (i_item.request_code)
                REQ_VOLTAGE: begin
                    n_result.has_response  = 1'b1;
                    n_result.response_data = div_prod[DIV100_SHIFT+7:DIV100_SHIFT];
                end
                REQ_STOP: begin
                    n_result.has_response  = 1'b1;
                    n_result.response_data = RSP_OK;
                    n_ign                  = 1'b0;
                    n_phase                = PH_STOPPED;
                    n_timed                = 1'b0;
                    n_result.notify        = NOTE_STOPPED;
                end
                REQ_LED_A, REQ_LED_B: begin
                    n_result.has_response  = 1'b1;
                    n_result.response_data = RSP_OK;
                    if (i_item.argument != ARG_USE_DEFAULT) begin
                        n_led = (i_item.argument != 8'd0);
                    end
                end
                REQ_START_10, REQ_START_15, REQ_START_20, REQ_START_25,
                REQ_START_30: begin
                    n_result.has_response = 1'b1;
                    if (i_item.mv > i_cfg.run_detect_mv) begin
                        n_phase                = PH_RUNNING;
                        n_result.response_data = RSP_ALREADY_RUN;
                        n_result.notify        = NOTE_ALREADY_RUN;
                    end else begin
                        n_min   = (i_item.argument != ARG_USE_DEFAULT) ?
                                  i_item.argument : i_cfg.default_run_minutes;
                        n_timed = 1'b1;
                        n_ign   = 1'b1;
                        n_phase = PH_IGN_WAIT;
                        n_seq   = '0;
                        n_result.response_data = RSP_STARTING;
                    end
                end
                default: begin
                end
            endcase
            if (n_result.has_response) begin
                n_result.response_code = RSP_CODE_BASE + i_item.request_code;
            end
        end

        n_result.ignition_relay = n_ign;
        n_result.starter_relay  = n_starter;
        n_result.led_drive      = n_led;
        n_result.engine_phase   = n_phase;
    end

    // State update, one item per take.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_STOPPED;
            r_ign     <= 1'b0;
            r_starter <= 1'b0;
            r_led     <= 1'b1;
            r_timed   <= 1'b0;
            r_min     <= '0;
            r_seq     <= '0;
            r_ms      <= '0;
            r_sec     <= '0;
        end else if (o_take) begin
            r_phase   <= n_phase;
            r_ign     <= n_ign;
            r_starter <= n_starter;
            r_led     <= n_led;
            r_timed   <= n_timed;
            r_min     <= n_min;
            r_seq     <= n_seq;
            r_ms      <= n_ms;
            r_sec     <= n_sec;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= n_result;
        end
    end

endmodule

// ===== src/engine_start_sequencer_core.sv =====
// ---------------------------------------------------------------------------
// engine_start_sequencer_core
// Remote engine-start controller: ignition delay, cranking, timed run.
// ---------------------------------------------------------------------------
// Each accepted item (a millisecond tick or a serial request, with a battery
// ADC sample) produces exactly one result transaction, and a new item can be
// accepted every cycle unless the result side stalls. The input register
// stores the sample already scaled to millivolts (the ADC-times-scale
// multiply); the step stage updates the sequencer state and divides the
// voltage by 100 through a reciprocal multiply into the result register.
// A stall on the result side reaches o_in_stall in the same cycle. The
// configuration port is always ready and takes one register write per cycle;
// writes are meant for idle periods only.
module engine_start_sequencer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Item input
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_command,
    input  logic [7:0]                      i_request_code,
    input  logic [7:0]                      i_argument,
    input  logic [9:0]                      i_adc_count,
    // Result output
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_has_response,
    output logic [7:0]                      o_response_code,
    output logic [7:0]                      o_response_data,
    output logic                            o_ignition_relay,
    output logic                            o_starter_relay,
    output logic                            o_led_drive,
    output logic [2:0]                      o_notify,
    output logic [1:0]                      o_engine_phase,
    // Configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ess_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ess_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ess_pkg::*;

    t_cfg    cfg;
    t_item   item;
    t_result result;
    logic    item_valid;
    logic    take;

    // Configuration registers.
    ess_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_ready (o_cfg_ready),
        .o_cfg   (cfg)
    );

    // Input register with voltage scaling.
    ess_input_stage u_input_stage (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_request_code (i_request_code),
        .i_argument     (i_argument),
        .i_adc_count    (i_adc_count),
        .i_mv_per_count (cfg.mv_per_count),
        .i_take         (take),
        .o_item_valid   (item_valid),
        .o_item         (item)
    );

    // Sequencer step and result register.
    ess_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .i_cfg        (cfg),
        .o_take       (take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_result     (result)
    );

    // Result fields onto the ports.
    assign o_has_response   = result.has_response;
    assign o_response_code  = result.response_code;
    assign o_response_data  = result.response_data;
    assign o_ignition_relay = result.ignition_relay;
    assign o_starter_relay  = result.starter_relay;
    assign o_led_drive      = result.led_drive;
    assign o_notify         = result.notify;
    assign o_engine_phase   = result.engine_phase;

endmodule

// ===== src/ess_checker.sv =====
// ---------------------------------------------------------------------------
// ess_checker
// Port-level checks for the engine start sequencer, bound to the top level.
// ---------------------------------------------------------------------------
`include "engine_start_sequencer_core_assert.svh"

module ess_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_stall,
    input  logic                            i_command,
    input  logic [7:0]                      i_request_code,
    input  logic [7:0]                      i_argument,
    input  logic [9:0]                      i_adc_count,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic                            o_has_response,
    input  logic [7:0]                      o_response_code,
    input  logic [7:0]                      o_response_data,
    input  logic                            o_ignition_relay,
    input  logic                            o_starter_relay,
    input  logic                            o_led_drive,
    input  logic [2:0]                      o_notify,
    input  logic [1:0]                      o_engine_phase,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [ess_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ess_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ess_pkg::*;

    // A stalled result stays valid and unchanged.
    `ESS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_response_data) && $stable(o_notify) && $stable(o_engine_phase))

    // The starter never runs without the ignition.
    `ESS_ASSERT_SAME(a_starter_needs_ign, i_clk, i_rst_n, o_out_valid && o_starter_relay, o_ignition_relay)

    // A stopped engine has both relays off.
    `ESS_ASSERT_SAME(a_stopped_relays_off, i_clk, i_rst_n, o_out_valid && (o_engine_phase == PH_STOPPED), !o_ignition_relay && !o_starter_relay)

    // Without a response, code and data are zero.
    `ESS_ASSERT_SAME(a_no_rsp_zero, i_clk, i_rst_n, o_out_valid && !o_has_response, (o_response_code == 8'd0) && (o_response_data == 8'd0))

endmodule

bind engine_start_sequencer_core ess_checker u_ess_checker (.*);
